### rtl/cdq_pkg.sv
// Package for the circular deque: command and status codes, payload structs
// and default sizing. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cdq_pkg;

    localparam int unsigned CDQ_DEPTH = 128;
    localparam int unsigned VAL_W     = 32;
    localparam int unsigned OCC_W     = 8;

    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_REAR  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_REAR   = 3'd3,
        CMD_PEEK_FRONT = 3'd4,
        CMD_PEEK_REAR  = 3'd5
    } cdq_cmd_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } cdq_status_t;

    localparam logic signed [VAL_W-1:0] NONE_VALUE = '1;

    typedef struct packed {
        logic [2:0]               command;
        logic signed [VAL_W-1:0]  push_value;
    } cdq_in_t;

    typedef struct packed {
        logic signed [VAL_W-1:0]  read_value;
        cdq_status_t              status;
        logic [OCC_W-1:0]         occupancy;
        logic                     is_empty;
        logic                     is_full;
    } cdq_out_t;

endpackage : cdq_pkg

`default_nettype wire

### rtl/cdq_ring_store.sv
// Ring store of the circular deque: single-port synchronous RAM with a
// registered read. Depends on cdq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cdq_ring_store
    import cdq_pkg::*;
#(
    parameter int unsigned DEPTH = CDQ_DEPTH,
    parameter int unsigned IW    = $clog2(DEPTH)
) (
    input  wire logic                    aclk,
    input  wire logic                    wr_en,
    input  wire logic                    rd_en,
    input  wire logic [IW-1:0]           addr,
    input  wire logic signed [VAL_W-1:0] wr_data,
    output logic signed [VAL_W-1:0]      rd_data
);

    logic signed [VAL_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[addr];
        end
    end

endmodule : cdq_ring_store

`default_nettype wire

### rtl/circular_deque_top.sv
// Top level of the circular deque: pointer control, result pipeline and
// output register. Depends on cdq_pkg and cdq_ring_store.
`timescale 1ns / 1ps
`default_nettype none

// Double-ended queue of DEPTH signed 32-bit entries held in a ring RAM.
//
// Input channel (s_valid/s_ready/s_data): one command per transfer, push or
// pop at either end, or peek at either end. Result channel
// (m_valid/m_ready/m_data): exactly one result per command, in order, with
// the value read (all ones on a push, a refusal or an unused command), a
// status code and the occupancy and empty/full flags after the command.
//
// A command's result passes through the read stage, where the registered RAM
// read loads at the transfer edge, and then the output register before it is
// offered. Throughput: one command per cycle while the receiver does not
// stall. Head, tail and count are updated at the transfer edge and the RAM
// is written or read in that same edge, so the next command sees the updated
// pointers and contents at once; the single RAM port is the limit.
//
// Reset (aresetn low, synchronous): head, tail and count return to zero and
// both pipeline stages empty. The RAM contents are not cleared; an entry is
// only ever read after a push has written it.
//
// Receiver stall: the output register holds its result while m_ready is low;
// one more command may still be taken into the read stage, after which
// s_ready drops until the output register drains.
module circular_deque_top
    import cdq_pkg::*;
#(
    parameter int unsigned DEPTH = CDQ_DEPTH
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire cdq_in_t  s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output cdq_out_t      m_data
);

    localparam int unsigned IW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    // pointer and occupancy state
    logic [IW-1:0] head_reg, head_next;
    logic [IW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;

    // read stage: command taken, RAM read in flight
    logic          a_valid_reg;
    logic          a_use_rd_reg, a_use_rd_next;
    cdq_out_t      a_meta_reg, a_meta_next;
    cdq_out_t      a_result;

    // output register
    logic          m_valid_reg;
    cdq_out_t      m_data_reg;

    logic                    s_fire;
    logic                    a_adv;
    logic                    full;
    logic                    empty;
    logic [IW-1:0]           head_dec;
    logic [IW-1:0]           head_inc;
    logic [IW-1:0]           tail_dec;
    logic [IW-1:0]           tail_inc;
    logic [IW-1:0]           mem_addr;
    logic                    mem_we;
    logic                    mem_re;
    cdq_status_t             status_next;
    logic signed [VAL_W-1:0] rd_data;

    assign full  = (count_reg == FULL_CNT);
    assign empty = (count_reg == '0);

    // wrap-around neighbours of both pointers
    assign head_dec = (head_reg == '0)       ? LAST_IDX : head_reg - 1'b1;
    assign head_inc = (head_reg == LAST_IDX) ? '0       : head_reg + 1'b1;
    assign tail_dec = (tail_reg == '0)       ? LAST_IDX : tail_reg - 1'b1;
    assign tail_inc = (tail_reg == LAST_IDX) ? '0       : tail_reg + 1'b1;

    // Advance the read stage when the output register is free or draining.
    assign a_adv   = !m_valid_reg || m_ready;
    assign s_ready = !a_valid_reg || a_adv;
    assign s_fire  = s_valid && s_ready;

    // Decode the command: pick the slot, the RAM access and new pointers.
    always_comb begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        mem_addr      = head_reg;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        a_use_rd_next = 1'b0;
        status_next   = ST_DONE;
        unique case (s_data.command)
            CMD_PUSH_FRONT: begin
                if (full) begin
                    status_next = ST_FULL;
                end else begin
                    head_next  = head_dec;
                    mem_addr   = head_dec;
                    mem_we     = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            CMD_PUSH_REAR: begin
                if (full) begin
                    status_next = ST_FULL;
                end else begin
                    tail_next  = tail_inc;
                    mem_addr   = tail_reg;
                    mem_we     = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            CMD_POP_FRONT, CMD_PEEK_FRONT: begin
                if (empty) begin
                    status_next = ST_EMPTY;
                end else begin
                    mem_addr      = head_reg;
                    mem_re        = 1'b1;
                    a_use_rd_next = 1'b1;
                    if (s_data.command == CMD_POP_FRONT) begin
                        head_next  = head_inc;
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            CMD_POP_REAR, CMD_PEEK_REAR: begin
                if (empty) begin
                    status_next = ST_EMPTY;
                end else begin
                    mem_addr      = tail_dec;
                    mem_re        = 1'b1;
                    a_use_rd_next = 1'b1;
                    if (s_data.command == CMD_POP_REAR) begin
                        tail_next  = tail_dec;
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            default: begin
                // unused command codes change nothing
            end
        endcase

        a_meta_next            = '0;
        a_meta_next.read_value = NONE_VALUE;
        a_meta_next.status     = status_next;
        a_meta_next.occupancy  = OCC_W'(count_next);
        a_meta_next.is_empty   = (count_next == '0);
        a_meta_next.is_full    = (count_next == FULL_CNT);
    end

    cdq_ring_store #(
        .DEPTH (DEPTH),
        .IW    (IW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (s_fire && mem_we),
        .rd_en   (s_fire && mem_re),
        .addr    (mem_addr),
        .wr_data (s_data.push_value),
        .rd_data (rd_data)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                count_reg <= count_next;
            end
            if (s_fire) begin
                a_valid_reg <= 1'b1;
            end else if (a_adv) begin
                a_valid_reg <= 1'b0;
            end
            if (a_adv) begin
                m_valid_reg <= a_valid_reg;
            end
        end
    end

    // merge the RAM read data into the waiting result
    always_comb begin
        a_result = a_meta_reg;
        if (a_use_rd_reg) begin
            a_result.read_value = rd_data;
        end
    end

    // payload: the RAM read data holds until the next read, so take the
    // merged result only when the transfer into the output register happens
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            a_meta_reg   <= a_meta_next;
            a_use_rd_reg <= a_use_rd_next;
        end
        if (a_adv && a_valid_reg) begin
            m_data_reg <= a_result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // occupancy never passes the store size
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT)
        else $error("entry count above depth");

    // an accepted push that is not refused adds exactly one entry
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && !full && (s_data.command == CMD_PUSH_FRONT ||
                            s_data.command == CMD_PUSH_REAR)
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("push did not grow the count");

    // head and tail coincide whenever the store is empty or full
    assert property (@(posedge aclk) disable iff (!aresetn)
        (empty || full) |-> head_reg == tail_reg)
        else $error("pointers disagree with count");

    // a refused command never returns stored data
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.status != ST_DONE
        |-> m_data_reg.read_value == NONE_VALUE)
        else $error("refusal carries a value");

    // a stalled result stays valid in the output register while m_ready is low
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |=> m_valid_reg)
        else $error("stalled result dropped");

endmodule : circular_deque_top

`default_nettype wire

### verif/cdq_result_checker.sv
// Result checker for the circular deque: keeps its own copy of the deque,
// predicts one result per command transfer and compares the result stream.
// Depends on cdq_pkg.
`timescale 1ns / 1ps

module cdq_result_checker
    import cdq_pkg::*;
#(
    parameter int unsigned DEPTH = CDQ_DEPTH
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    input  wire logic     s_ready,
    input  wire cdq_in_t  s_data,
    input  wire logic     m_valid,
    input  wire logic     m_ready,
    input  wire cdq_out_t m_data,
    output int unsigned   pending,
    output int unsigned   fail_count
);

    logic signed [VAL_W-1:0] deque_store [DEPTH];
    int unsigned             front_slot;
    int unsigned             back_slot;
    int unsigned             held;
    cdq_out_t                results_due [$];
    int unsigned             mismatches;

    // Apply one command to the shadow deque and return what the block owes.
    function automatic cdq_out_t apply_command(cdq_in_t c);
        cdq_out_t r;
        r.read_value = NONE_VALUE;
        r.status     = ST_DONE;
        case (c.command)
            CMD_PUSH_FRONT: begin
                if (held == DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    front_slot = (front_slot + DEPTH - 1) % DEPTH;
                    deque_store[front_slot] = c.push_value;
                    held++;
                end
            end
            CMD_PUSH_REAR: begin
                if (held == DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    deque_store[back_slot] = c.push_value;
                    back_slot = (back_slot + 1) % DEPTH;
                    held++;
                end
            end
            CMD_POP_FRONT: begin
                if (held == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.read_value = deque_store[front_slot];
                    front_slot = (front_slot + 1) % DEPTH;
                    held--;
                end
            end
            CMD_POP_REAR: begin
                if (held == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    back_slot = (back_slot + DEPTH - 1) % DEPTH;
                    r.read_value = deque_store[back_slot];
                    held--;
                end
            end
            CMD_PEEK_FRONT: begin
                if (held == 0) r.status = ST_EMPTY;
                else r.read_value = deque_store[front_slot];
            end
            CMD_PEEK_REAR: begin
                if (held == 0) r.status = ST_EMPTY;
                else r.read_value = deque_store[(back_slot + DEPTH - 1) % DEPTH];
            end
            default: ;
        endcase
        r.occupancy = OCC_W'(held);
        r.is_empty  = (held == 0);
        r.is_full   = (held == DEPTH);
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        cdq_out_t due;
        if (!aresetn) begin
            front_slot = 0;
            back_slot  = 0;
            held       = 0;
            results_due.delete();
        end else begin
            // compare first: a result never belongs to a command taken at the same edge
            if (m_valid && m_ready) begin
                if (results_due.size() == 0) begin
                    $error("result transfer with no command outstanding");
                    mismatches++;
                end else begin
                    due = results_due.pop_front();
                    if (m_data.read_value !== due.read_value) begin
                        $error("read_value: expected %0d, actual %0d",
                               due.read_value, m_data.read_value);
                        mismatches++;
                    end
                    if (m_data.status !== due.status) begin
                        $error("status: expected %0d, actual %0d", due.status, m_data.status);
                        mismatches++;
                    end
                    if (m_data.occupancy !== due.occupancy) begin
                        $error("occupancy: expected %0d, actual %0d",
                               due.occupancy, m_data.occupancy);
                        mismatches++;
                    end
                    if (m_data.is_empty !== due.is_empty) begin
                        $error("is_empty: expected %0b, actual %0b",
                               due.is_empty, m_data.is_empty);
                        mismatches++;
                    end
                    if (m_data.is_full !== due.is_full) begin
                        $error("is_full: expected %0b, actual %0b", due.is_full, m_data.is_full);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready) results_due.push_back(apply_command(s_data));
        end
        pending    <= results_due.size();
        fail_count <= mismatches;
    end

endmodule

### verif/tb_circular_deque_top.sv
// Testbench top for the circular deque: clock, reset, command stimulus,
// receiver back-pressure and the verdict. Depends on cdq_pkg,
// circular_deque_top and cdq_result_checker.
`timescale 1ns / 1ps

module tb_circular_deque_top;
    import cdq_pkg::*;

    localparam int unsigned DEPTH        = CDQ_DEPTH;
    localparam int          RANDOM_ITEMS = 1850;
    localparam int          QUIET_ITEMS  = 250;     // tail of the run with no idling
    localparam int          HOLD_AT      = 400;     // commands sent before the long hold-off
    localparam int          HOLD_CYCLES  = 300;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          CYCLE_LIMIT  = 250000;

    // Command codes the block must treat as no-ops.
    localparam logic [2:0] CMD_SPARE_A = 3'd6;
    localparam logic [2:0] CMD_SPARE_B = 3'd7;

    typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    cdq_in_t     s_data;
    logic        m_valid;
    logic        m_ready;
    cdq_out_t    m_data;

    int unsigned pending;
    int unsigned fail_count;
    int          items_sent;
    int          send_odds;     // 0: no sender gaps, else one gap in send_odds transfers
    bit          quiet_tail;
    bit          held_off;
    int          cycle_count;

    circular_deque_top #(.DEPTH(DEPTH)) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    cdq_result_checker #(.DEPTH(DEPTH)) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .pending    (pending),
        .fail_count (fail_count)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Give up on a hung block: nothing correct takes this long.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Offer one command and hold it, payload unchanged, until the transfer.
    // Afterwards drop valid for a random burst when the current window allows
    // gaps; otherwise leave valid high so the next command follows at once.
    task automatic offer(input logic [2:0] cmd, input logic signed [VAL_W-1:0] val);
        s_valid <= 1'b1;
        s_data  <= '{command: cmd, push_value: val};
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (!quiet_tail && send_odds != 0 && $urandom_range(1, send_odds) == 1) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    endtask

    // Receiver: random stall bursts with odds drawn anew for each window, some
    // windows with none, one long hold-off so the block fills and stalls its input,
    // and no stalls at all once the quiet tail starts.
    initial begin : receiver
        int take_odds;
        int window;
        m_ready   <= 1'b0;
        take_odds = 0;
        window    = 0;
        @(posedge aclk iff aresetn);
        forever begin
            @(posedge aclk);
            if (window == 0) begin
                case ($urandom_range(0, 2))
                    0:       take_odds = 0;
                    1:       take_odds = 4;
                    default: take_odds = 16;
                endcase
                window = 64;
            end
            window--;
            if (!held_off && items_sent >= HOLD_AT) begin
                held_off = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (!quiet_tail && take_odds != 0 && $urandom_range(1, take_odds) == 1) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        phase_t                  phase;
        int                      phase_left;
        int                      roll;
        logic [2:0]              cmd;
        logic signed [VAL_W-1:0] val;

        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_data      <= '0;
        items_sent  = 0;
        send_odds   = 4;
        quiet_tail  = 1'b0;
        phase       = PH_FILL;
        phase_left  = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Refusals on an empty deque, and the spare codes.
        offer(CMD_POP_FRONT,  $urandom);
        offer(CMD_POP_REAR,   $urandom);
        offer(CMD_PEEK_FRONT, $urandom);
        offer(CMD_PEEK_REAR,  $urandom);
        offer(CMD_SPARE_A,    $urandom);
        offer(CMD_SPARE_B,    $urandom);
        // Extreme values at both ends; the first push front wraps the head below slot 0.
        offer(CMD_PUSH_FRONT, 32'sh7FFF_FFFF);
        offer(CMD_PUSH_REAR,  32'sh8000_0000);
        offer(CMD_PUSH_FRONT, -32'sd1);
        offer(CMD_PUSH_REAR,  32'sd0);
        offer(CMD_PUSH_REAR,  32'sh5A5A_5A5A);
        offer(CMD_PUSH_FRONT, 32'shA5A5_A5A5);
        // Read them back from both ends, including a stored all-ones entry.
        offer(CMD_PEEK_FRONT, $urandom);
        offer(CMD_PEEK_REAR,  $urandom);
        offer(CMD_POP_FRONT,  $urandom);
        offer(CMD_POP_REAR,   $urandom);
        offer(CMD_SPARE_A,    $urandom);
        offer(CMD_POP_FRONT,  $urandom);
        offer(CMD_POP_REAR,   $urandom);
        offer(CMD_PEEK_FRONT, $urandom);
        offer(CMD_PEEK_REAR,  $urandom);
        offer(CMD_POP_REAR,   $urandom);
        offer(CMD_POP_FRONT,  $urandom);
        offer(CMD_POP_REAR,   $urandom);

        // Random part in phases: fill runs long enough to reach full and
        // bounce off it, drain runs empty the deque again, mixed runs use
        // every code. Pointers wrap many times over.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet_tail = 1'b1;
            if (n % 64 == 0) begin
                case ($urandom_range(0, 2))
                    0:       send_odds = 0;
                    1:       send_odds = 3;
                    default: send_odds = 10;
                endcase
            end
            if (phase_left == 0) begin
                phase      = phase_t'($urandom_range(0, 2));
                phase_left = (phase == PH_MIXED) ? $urandom_range(20, 80)
                                                 : $urandom_range(60, 220);
            end
            phase_left--;

            roll = $urandom_range(0, 19);
            case (phase)
                PH_FILL: begin
                    if (roll < 9)       cmd = CMD_PUSH_FRONT;
                    else if (roll < 18) cmd = CMD_PUSH_REAR;
                    else                cmd = 3'($urandom_range(0, 7));
                end
                PH_DRAIN: begin
                    if (roll < 8)       cmd = CMD_POP_FRONT;
                    else if (roll < 16) cmd = CMD_POP_REAR;
                    else                cmd = 3'($urandom_range(0, 7));
                end
                default: cmd = 3'($urandom_range(0, 7));
            endcase

            case ($urandom_range(0, 9))
                0:       val = 32'sh7FFF_FFFF;
                1:       val = 32'sh8000_0000;
                2:       val = -32'sd1;
                3:       val = 32'sd0;
                4:       val = VAL_W'($urandom_range(0, 255));
                default: val = $urandom;
            endcase
            offer(cmd, val);
        end

        // Close the input, let the checker see the last transfer, then wait
        // for every outstanding result and a little longer for strays.
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
